>>> sv/i2a_pkg.sv
// shared types, character codes and power-of-ten table for the decimal text converter
`default_nettype none

package i2a_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned STEP_W  = 34;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    // one classified value waiting for the digit engine
    typedef struct packed {
        logic              neg;
        logic [WORD_W-1:0] mag;
        logic [POS_W-1:0]  top;
    } t_item;

    function automatic logic [WORD_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [WORD_W-1:0] p;
        case (pos)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> sv/i2a_front.sv
// front stage: takes a value, forms sign, magnitude and leading-digit index, pushes to the queue
`default_nettype none

module i2a_front
    import i2a_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [WORD_W-1:0] i_value,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output t_item                  o_q_item
);

    logic              r_vld;
    logic [WORD_W-1:0] r_word;
    logic              n_vld;
    logic              load;
    logic [WORD_W-1:0] mag;
    logic [9:1]        ge;
    logic [POS_W-1:0]  top;

    assign o_stall  = r_vld && i_q_full;
    assign o_q_push = r_vld && !i_q_full;
    assign load     = i_valid && !o_stall;

    // magnitude as unsigned, so the most negative value needs no special path
    assign mag = r_word[WORD_W-1] ? (~r_word + 32'd1) : r_word;

    always_comb begin
        top = '0;
        for (int k = 1; k <= 9; k++) begin
            ge[k] = (mag >= pow10(POS_W'(k)));
            top   = top + POS_W'(ge[k]);
        end
    end

    assign o_q_item = '{neg: r_word[WORD_W-1], mag: mag, top: top};

    always_comb begin
        n_vld = r_vld;
        if (load) begin
            n_vld = 1'b1;
        end else if (o_q_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (load) begin
            r_word <= i_value;
        end
    end

endmodule

`default_nettype wire

>>> sv/i2a_queue.sv
// two-entry queue between the front stage and the digit engine
`default_nettype none

module i2a_queue
    import i2a_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_nonempty,
    output t_item      o_item
);

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_item     = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/i2a_back.sv
// digit engine: emits sign then one decimal digit per cycle while the output is not stalled, most significant first
`default_nettype none

module i2a_back
    import i2a_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_nonempty,
    input  wire t_item             i_q_item,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [CHAR_W-1:0]      o_ascii_char,
    output logic                   o_last
);

    logic              r_act;
    logic              r_neg;
    logic [WORD_W-1:0] r_rem;
    logic [POS_W-1:0]  r_pos;
    logic              r_ovld;
    logic [CHAR_W-1:0] r_ochar;
    logic              r_olast;

    logic                adv;
    logic                fin;
    logic [WORD_W-1:0]   pw;
    logic [STEP_W:0]     diff [1:9];
    logic [9:1]          ge;
    logic [DIGIT_W-1:0]  digit;
    logic [WORD_W-1:0]   n_rem;
    logic [CHAR_W-1:0]   n_char;
    logic                n_last;

    assign adv     = !r_ovld || !i_stall;
    assign pw      = pow10(r_pos);

    // trial subtraction of one to nine times the current power of ten
    always_comb begin
        digit = '0;
        n_rem = r_rem;
        for (int k = 1; k <= 9; k++) begin
            diff[k] = {3'b000, r_rem} - ({3'b000, pw} * (STEP_W+1)'(k));
            ge[k]   = !diff[k][STEP_W];
            if (ge[k]) begin
                digit = DIGIT_W'(k);
                n_rem = diff[k][WORD_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            n_char = CHAR_MINUS;
            n_last = 1'b0;
        end else begin
            n_char = CHAR_ZERO + CHAR_W'(digit);
            n_last = (r_pos == '0);
        end
    end

    assign fin     = r_act && adv && n_last;
    assign o_q_pop = i_q_nonempty && (!r_act || fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (adv) begin
                r_ovld <= r_act;
            end
            if (o_q_pop) begin
                r_act <= 1'b1;
            end else if (fin) begin
                r_act <= 1'b0;
            end
        end
        if (adv) begin
            r_ochar <= n_char;
            r_olast <= n_last;
        end
        if (o_q_pop) begin
            r_neg <= i_q_item.neg;
            r_rem <= i_q_item.mag;
            r_pos <= i_q_item.top;
        end else if (r_act && adv) begin
            if (r_neg) begin
                r_neg <= 1'b0;
            end else begin
                r_rem <= n_rem;
                r_pos <= r_pos - POS_W'(1);
            end
        end
    end

    assign o_valid      = r_ovld;
    assign o_ascii_char = r_ochar;
    assign o_last       = r_olast;

endmodule

`default_nettype wire

>>> sv/int32_to_decimal_ascii_core.sv
// top level: signed 32-bit value in, decimal ascii characters out
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  input   | in        | i_valid / o_stall  | i_value (32b signed)
//  output  | out       | o_valid / i_stall  | o_ascii_char (7b), o_last
//
// one character leaves per cycle while i_stall is low: a value gives 1 to 11
// characters, set by the digit engine's one-digit-per-cycle loop
// first character passes the input register, the queue, the digit engine state
// and the output register in that order; the output register drives the port
// synchronous active-low reset empties every stage; no clearing pass
// stalls on the output back up through the queue into the front register

`default_nettype none

module int32_to_decimal_ascii_core
    import i2a_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [WORD_W-1:0]   i_value,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [CHAR_W-1:0]        o_ascii_char,
    output logic                     o_last
);

    // front to queue
    logic  q_push;
    logic  q_full;
    t_item q_in;

    // queue to digit engine
    logic  q_pop;
    logic  q_nonempty;
    t_item q_out;

    // classify: sign, unsigned magnitude, index of leading digit
    i2a_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_in)
    );

    // lets the front keep taking values while a long number is still being printed
    i2a_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_item     (q_in),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_item     (q_out)
    );

    // sign, then digits msb first; the next value is pulled on the final digit
    i2a_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_item     (q_out),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    // the front never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // a minus sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_ascii_char == CHAR_MINUS)) |-> !o_last)
        else $error("minus sign flagged last");

    // characters of one value follow without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("gap inside a number's text");
`endif

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// self-checking testbench for the signed int32 to decimal ascii converter
module tb_top
    import i2a_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // run limits
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;   // idle margin after the last owed character has come back
    localparam int MAX_REPORTS   = 10;

    // one expected character of the decimal text
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [WORD_W-1:0] i_value = '0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [CHAR_W-1:0] o_ascii_char;
    logic              o_last;

    // characters still owed by the block, oldest first
    t_char pending_chars[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int rx_hold_len   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    int32_to_decimal_ascii_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

    always #10 i_clk = ~i_clk;

    // expected text of one value: optional minus, then digits with leading
    // zeros dropped; the magnitude is unsigned so the most negative value works
    function automatic void queue_decimal_text(input logic [WORD_W-1:0] word);
        logic              neg;
        logic [WORD_W-1:0] mag;
        logic [DIGIT_W-1:0] digit [10];
        int                top;
        t_char             c;
        neg = word[WORD_W-1];
        mag = neg ? (~word + 1'b1) : word;
        for (int i = 0; i < 10; i++) begin
            digit[i] = DIGIT_W'(mag % 32'd10);
            mag      = mag / 32'd10;
        end
        top = 9;
        while (top > 0 && digit[top] == '0)
            top--;
        if (neg) begin
            c.ch   = CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (int p = top; p >= 0; p--) begin
            c.ch   = CHAR_ZERO + CHAR_W'(digit[p]);
            c.last = (p == 0);
            pending_chars.push_back(c);
        end
    endfunction

    // mix of digit counts and signs, with the extremes sprinkled in
    function automatic logic [WORD_W-1:0] random_value();
        int unsigned       pick;
        int unsigned       ndig;
        longint unsigned   lo;
        longint unsigned   hi;
        logic [WORD_W-1:0] w;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return $urandom();
        if (pick == 1) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        ndig = $urandom_range(1, 10);
        lo   = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi   = lo * 10 - 1;
        if (ndig == 1)
            lo = 0;
        if (hi > 64'd2147483647)
            hi = 64'd2147483647;
        w = $urandom_range(32'(hi), 32'(lo));
        if ($urandom_range(0, 1) == 1)
            w = ~w + 1'b1;
        return w;
    endfunction

    task automatic report_failure(input string what, input t_char want, input t_char got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                     $realtime, what, want.ch, want.last, got.ch, got.last);
    endtask

    // predict on every accepted input transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            queue_decimal_text(i_value);
    end

    // compare every accepted output transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_char want;
        t_char got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.ch   = o_ascii_char;
            got.last = o_last;
            if (pending_chars.size() == 0) begin
                want = '0;
                report_failure("unexpected character", want, got);
            end else begin
                want = pending_chars.pop_front();
                if (got !== want)
                    report_failure("character mismatch", want, got);
            end
        end
    end

    // receiver stall: random at the phase rate, or a long hold-off on request
    always @(posedge i_clk) begin
        if (holds_served != hold_requests) begin
            hold_left    = rx_hold_len;
            holds_served = holds_served + 1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("int32_to_decimal_ascii_core verification failed");
            $finish;
        end
    end

    // one input transaction; valid stays up across back-to-back values
    task automatic send_value(input logic [WORD_W-1:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // sender goes quiet until every owed character has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_value(random_value());
    endtask

    // extremes, zero, sign handling and digit counts of one, two, three, five, nine and ten
    task automatic test_directed();
        logic [WORD_W-1:0] vals [$];
        vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd100,
                 32'd12345, -32'sd7, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890,
                 -32'sd90817};
        set_idling(0, 0);
        foreach (vals[k])
            send_value(vals[k]);
        wait_drained();
    endtask

    task automatic test_steady_stream();
        set_idling(0, 0);
        send_random(30);
        wait_drained();
    endtask

    task automatic test_sender_idle();
        set_idling(68, 0);
        send_random(30);
        wait_drained();
    endtask

    task automatic test_receiver_stall();
        set_idling(0, 68);
        send_random(30);
        wait_drained();
    endtask

    task automatic test_both_idle();
        set_idling(9, 9);
        send_random(30);
        wait_drained();
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        set_idling(0, 0);
        rx_hold_len   = 400;
        hold_requests = hold_requests + 1;
        send_random(24);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_steady_stream();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();

        if (fail_count == 0 && pending_chars.size() == 0) begin
            $display("int32_to_decimal_ascii_core verification clean");
        end else begin
            $display("int32_to_decimal_ascii_core verification failed");
        end
        $finish;
    end

endmodule
